// ===== sv/sawd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sawd_pkg
// Shared codes, defaults and controller/datapath interface types for the
// stack with adjacent duplicate removal.
// ----------------------------------------------------------------------------
package sawd_pkg;

	localparam int DEF_STACK_DEPTH = 256;
	localparam int DEF_KEY_BITS    = 31;
	localparam int KIND_BITS       = 2;
	localparam int STATUS_BITS     = 2;
	localparam int COUNT_BITS      = 9;

	typedef enum logic [KIND_BITS-1:0] {
		CMD_PUSH    = 2'd0,
		CMD_POP     = 2'd1,
		CMD_COMPACT = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_CMP,
		S_FIN
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic    do_push;
		logic    do_pop;
		logic    cmp_start;
		logic    cmp_step;
		logic    out_load;
		logic    use_rdata;
		status_t status;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic full;
		logic short_stack;
		logic cmp_last;
	} dp_sts_t;

endpackage : sawd_pkg
`default_nettype wire

// ===== sv/sawd_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sawd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sawd_ram #(
	parameter int WIDTH = sawd_pkg::DEF_KEY_BITS,
	parameter int DEPTH = sawd_pkg::DEF_STACK_DEPTH
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule : sawd_ram
`default_nettype wire

// ===== sv/sawd_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sawd_ctrl
// Command sequencer: decodes accepted words, steps the compact walk and
// owns the result valid flag.
// ----------------------------------------------------------------------------
module sawd_ctrl (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	input  wire logic [sawd_pkg::KIND_BITS-1:0]        kind,
	output logic                                       in_stall,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	input  wire sawd_pkg::dp_sts_t                     sts,
	output sawd_pkg::dp_cmd_t                          cmd
);

	sawd_pkg::state_t state_q;
	sawd_pkg::state_t state_d;
	sawd_pkg::cmd_t   kind_c;
	logic             out_valid_q;
	logic             out_free;
	logic             accept;

	assign kind_c   = sawd_pkg::cmd_t'(kind);
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != sawd_pkg::S_IDLE) || !out_free;
	assign accept   = in_valid && !in_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sawd_pkg::S_IDLE: begin
				if (accept) begin
					if (kind_c == sawd_pkg::CMD_POP && !sts.empty) begin
						state_d = sawd_pkg::S_POP;
					end else if (kind_c == sawd_pkg::CMD_COMPACT && !sts.short_stack) begin
						state_d = sawd_pkg::S_CMP;
					end
				end
			end
			sawd_pkg::S_POP: begin
				if (out_free) begin
					state_d = sawd_pkg::S_IDLE;
				end
			end
			sawd_pkg::S_CMP: begin
				if (sts.cmp_last) begin
					state_d = sawd_pkg::S_FIN;
				end
			end
			sawd_pkg::S_FIN: begin
				if (out_free) begin
					state_d = sawd_pkg::S_IDLE;
				end
			end
			default: state_d = sawd_pkg::S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		cmd.status = sawd_pkg::ST_OK;
		unique case (state_q)
			sawd_pkg::S_IDLE: begin
				if (accept) begin
					unique case (kind_c)
						sawd_pkg::CMD_PUSH: begin
							cmd.out_load = 1'b1;
							if (sts.full) begin
								cmd.status = sawd_pkg::ST_FULL;
							end else begin
								cmd.do_push = 1'b1;
							end
						end
						sawd_pkg::CMD_POP: begin
							if (sts.empty) begin
								cmd.out_load = 1'b1;
								cmd.status   = sawd_pkg::ST_EMPTY;
							end else begin
								cmd.do_pop = 1'b1;
							end
						end
						sawd_pkg::CMD_COMPACT: begin
							if (sts.short_stack) begin
								cmd.out_load = 1'b1;
							end else begin
								cmd.cmp_start = 1'b1;
							end
						end
						sawd_pkg::CMD_NOP: begin
							cmd.out_load = 1'b1;
						end
						default: cmd.out_load = 1'b1;
					endcase
				end
			end
			sawd_pkg::S_POP: begin
				cmd.out_load  = out_free;
				cmd.use_rdata = 1'b1;
			end
			sawd_pkg::S_CMP: begin
				cmd.cmp_step = 1'b1;
			end
			sawd_pkg::S_FIN: begin
				cmd.out_load = out_free;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sawd_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= cmd.out_load || (out_valid_q && out_stall);
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	// never overwrite a result that is still held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result overwritten while stalled");

	// an accepted pop on a non-empty stack enters the read wait state in the next cycle
	a_pop_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind_c == sawd_pkg::CMD_POP && !sts.empty) |=>
		(state_q == sawd_pkg::S_POP))
		else $error("pop did not enter read wait");

	// hold the input while a command is in flight
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != sawd_pkg::S_IDLE) |-> in_stall)
		else $error("input open while busy");
`endif

endmodule : sawd_ctrl
`default_nettype wire

// ===== sv/sawd_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sawd_dp
// Stack datapath: height and walk counters, key store and result registers.
// ----------------------------------------------------------------------------
module sawd_dp #(
	parameter int STACK_DEPTH = sawd_pkg::DEF_STACK_DEPTH,
	parameter int KEY_BITS    = sawd_pkg::DEF_KEY_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [KEY_BITS-1:0]                 key,
	input  wire sawd_pkg::dp_cmd_t                   cmd,
	output sawd_pkg::dp_sts_t                        sts,
	output logic      [KEY_BITS-1:0]                 popped_key,
	output logic      [sawd_pkg::STATUS_BITS-1:0]    status,
	output logic                                     is_empty,
	output logic      [sawd_pkg::COUNT_BITS-1:0]     entry_count
);

	localparam int HB = $clog2(STACK_DEPTH + 1);
	localparam int AB = $clog2(STACK_DEPTH);

	logic [HB-1:0]       height_q;
	logic [HB-1:0]       height_d;
	logic [HB-1:0]       rd_q;
	logic [HB-1:0]       wr_q;
	logic [KEY_BITS-1:0] last_q;
	logic [HB-1:0]       height_m1;

	logic                ram_we;
	logic [AB-1:0]       ram_waddr;
	logic [KEY_BITS-1:0] ram_wdata;
	logic                ram_re;
	logic [AB-1:0]       ram_raddr;
	logic [KEY_BITS-1:0] ram_rdata;
	logic                keep;

	logic [KEY_BITS-1:0]              popped_key_q;
	sawd_pkg::status_t                status_q;
	logic                             is_empty_q;
	logic [sawd_pkg::COUNT_BITS-1:0]  entry_count_q;

	assign height_m1       = height_q - HB'(1);
	assign sts.empty       = (height_q == '0);
	assign sts.full        = (height_q == HB'(STACK_DEPTH));
	assign sts.short_stack = (height_q <= HB'(1));
	assign sts.cmp_last    = (rd_q == height_q);

	// start a new run on the first entry or on a change of key
	assign keep = (wr_q == '0) || (ram_rdata != last_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = height_q[AB-1:0];
		ram_wdata = key;
		ram_re    = 1'b0;
		ram_raddr = height_m1[AB-1:0];
		height_d  = height_q;
		if (cmd.do_push) begin
			ram_we   = 1'b1;
			height_d = height_q + HB'(1);
		end
		if (cmd.do_pop) begin
			ram_re   = 1'b1;
			height_d = height_m1;
		end
		if (cmd.cmp_start) begin
			ram_re    = 1'b1;
			ram_raddr = '0;
		end
		if (cmd.cmp_step) begin
			ram_we    = keep;
			ram_waddr = wr_q[AB-1:0];
			ram_wdata = ram_rdata;
			ram_re    = !sts.cmp_last;
			ram_raddr = rd_q[AB-1:0];
			if (sts.cmp_last) begin
				height_d = wr_q + HB'(keep);
			end
		end
	end

	sawd_ram #(
		.WIDTH (KEY_BITS),
		.DEPTH (STACK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= '0;
			rd_q     <= '0;
			wr_q     <= '0;
		end else begin
			height_q <= height_d;
			if (cmd.cmp_start) begin
				rd_q <= HB'(1);
				wr_q <= '0;
			end else if (cmd.cmp_step) begin
				if (!sts.cmp_last) begin
					rd_q <= rd_q + HB'(1);
				end
				if (keep) begin
					wr_q <= wr_q + HB'(1);
				end
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (cmd.cmp_step && keep) begin
			last_q <= ram_rdata;
		end
		if (cmd.out_load) begin
			popped_key_q  <= cmd.use_rdata ? ram_rdata : '0;
			status_q      <= cmd.status;
			is_empty_q    <= (height_d == '0);
			entry_count_q <= sawd_pkg::COUNT_BITS'(height_d);
		end
	end

	assign popped_key  = popped_key_q;
	assign status      = status_q;
	assign is_empty    = is_empty_q;
	assign entry_count = entry_count_q;

`ifndef SYNTHESIS
	a_height_range: assert property (@(posedge clk) disable iff (!arst_n)
		height_q <= HB'(STACK_DEPTH))
		else $error("stack height beyond depth");

	// compact writes trail its reads
	a_wr_behind_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cmp_step |-> (wr_q < rd_q))
		else $error("compact write overtook read");

	a_cmp_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.cmp_step && sts.cmp_last) |=> (height_q <= $past(height_q)))
		else $error("compact grew the stack");
`endif

endmodule : sawd_dp
`default_nettype wire

// ===== sv/stack_with_adjacent_dedup_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stack_with_adjacent_dedup_core
// Bounded LIFO stack of keys with push, pop and in-place removal of
// adjacent duplicate keys. One result word per command word.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            payload
//  -------  ---  -------------------  ------------------------------------------
//  in       in   in_valid / in_stall  kind, key
//  out      out  out_valid/out_stall  popped_key, status, is_empty, entry_count
//
//  Push, a pop on an empty stack, a trivial compact and the unused kind load
//  the result when accepted. Pop waits for the key store's registered read.
//  Compact: one stored key read and compared per cycle.
//  Reset clears height and control; the key store is not cleared.
//  A held result word under stall blocks the input until it is taken.
//
module stack_with_adjacent_dedup_core #(
	parameter int STACK_DEPTH = sawd_pkg::DEF_STACK_DEPTH,
	parameter int KEY_BITS    = sawd_pkg::DEF_KEY_BITS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// command words
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [sawd_pkg::KIND_BITS-1:0]    kind,
	input  wire logic [KEY_BITS-1:0]               key,
	// result words
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [KEY_BITS-1:0]               popped_key,
	output logic      [sawd_pkg::STATUS_BITS-1:0]  status,
	output logic                                   is_empty,
	output logic      [sawd_pkg::COUNT_BITS-1:0]   entry_count
);

	sawd_pkg::dp_cmd_t cmd;
	sawd_pkg::dp_sts_t sts;

	// sequencer: decode, walk compact, hold result valid
	sawd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.kind      (kind),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: key store, height, walk pointers, result registers
	sawd_dp #(
		.STACK_DEPTH (STACK_DEPTH),
		.KEY_BITS    (KEY_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.key         (key),
		.cmd         (cmd),
		.sts         (sts),
		.popped_key  (popped_key),
		.status      (status),
		.is_empty    (is_empty),
		.entry_count (entry_count)
	);

endmodule : stack_with_adjacent_dedup_core
`default_nettype wire
